>>> rtl/sia_pkg.sv
package sia_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // decimal digits needed for 2^(w-1), the largest magnitude at width w
    function automatic int dec_digits(input int w);
        logic [63:0] v;
        int          n;
        v = 64'd1 << (w - 1);
        n = 0;
        for (int i = 0; i < 24; i++) begin
            if (v != 64'd0) begin
                v = v / 64'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/sia_front.sv
module sia_front
    import sia_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_q_full,
    output logic                   o_busy,
    output logic                   o_q_push,
    output logic [VALUE_WIDTH:0]   o_q_data
);

    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    // magnitude stays unsigned within the width, so the most negative value fits
    assign neg      = i_value[VALUE_WIDTH-1];
    assign mag      = neg ? (~i_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : i_value;
    assign o_busy   = i_q_full;
    assign o_q_push = i_start & ~i_q_full;
    assign o_q_data = {neg, mag};

endmodule

>>> rtl/sia_queue.sv
module sia_queue
    import sia_pkg::*;
#(
    parameter int DATA_W = VALUE_WIDTH_DEF + 1,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/sia_back.sv
module sia_back
    import sia_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  logic [VALUE_WIDTH:0] i_q_data,
    output logic                 o_q_pop,
    output logic                 o_valid,
    output logic [7:0]           o_char_code,
    output logic                 o_last
);

    localparam int ND     = dec_digits(VALUE_WIDTH);
    localparam int BCD_W  = 4 * ND;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W = $clog2(ND + 1);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BCD_W-1:0]       r_bcd;
    logic [CNT_W-1:0]       r_cnt;
    logic [LEFT_W-1:0]      r_left;
    logic                   r_lead;
    logic                   r_valid;
    logic [7:0]             r_char;
    logic                   r_last;
    logic [3:0]             top;
    logic [BCD_W-1:0]       bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int d = 0; d < ND; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
                r[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    assign top         = r_bcd[BCD_W-1 -: 4];
    assign bcd_adj     = bcd_adjust(r_bcd);
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_lead  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_mag   <= i_q_data[VALUE_WIDTH-1:0];
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(VALUE_WIDTH);
                        r_state <= S_CONV;
                        // sign leaves right away, digits follow after conversion
                        if (i_q_data[VALUE_WIDTH]) begin
                            r_valid <= 1'b1;
                            r_char  <= CH_MINUS;
                            r_last  <= 1'b0;
                        end
                    end
                end
                S_CONV: begin
                    r_bcd <= {bcd_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                    r_mag <= r_mag << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_left  <= LEFT_W'(ND);
                        r_lead  <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_bcd  <= r_bcd << 4;
                    r_left <= r_left - 1'b1;
                    // leading zeros are dropped, but the units digit always goes out
                    if (!(r_lead && top == 4'd0 && r_left > LEFT_W'(1))) begin
                        r_valid <= 1'b1;
                        r_char  <= CH_ZERO + {4'd0, top};
                        r_last  <= (r_left == LEFT_W'(1));
                        r_lead  <= 1'b0;
                    end
                    if (r_left == LEFT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// channel   direction  handshake           payload
// command   in         start, busy         i_value (signed, VALUE_WIDTH bits)
// result    out        o_valid (strobe)    o_char_code (8 bits), o_last
//
// an item is loaded, converted by shift-add-3 steps in the back end, one per value bit,
// and sent out over one slot per decimal digit (10 at 32 bits)
// a minus sign shows in the cycle after the item leaves the queue, the digit slots
// follow once the conversion is done
// a QUEUE_DEPTH-entry queue takes new items during conversion; busy is queue full
// reset clears the queue and the sequencer; results cannot be held off
module signed_int_to_decimal_ascii
    import sia_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic [7:0]             o_char_code,
    output logic                   o_last
);

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_valid;
    logic [VALUE_WIDTH:0] q_wdata;
    logic [VALUE_WIDTH:0] q_rdata;

    sia_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_start (start),
        .i_value (i_value),
        .i_q_full(q_full),
        .o_busy  (busy),
        .o_q_push(q_push),
        .o_q_data(q_wdata)
    );

    sia_queue #(
        .DATA_W(VALUE_WIDTH + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_rdata)
    );

    sia_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

`ifndef NO_ASSERTIONS
    // conversion runs after the sign goes out, so no character follows it directly
    a_gap_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == CH_MINUS) |=> !o_valid)
        else $error("character right after the minus sign");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == CH_MINUS) |-> !o_last)
        else $error("minus sign marked as last");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CH_MINUS ||
                     (o_char_code >= CH_ZERO && o_char_code <= CH_NINE)))
        else $error("character outside sign and digits");
`endif

endmodule

>>> bench/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
    import sia_pkg::*;

    localparam int W = VALUE_WIDTH_DEF;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    // empty text: expected characters come from the decimal predictor
    typedef struct {
        logic [W-1:0] value;
        string        text;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    logic [W-1:0] i_value = '0;
    logic         busy;
    logic         o_valid;
    logic [7:0]   o_char_code;
    logic         o_last;

    t_text_char pending_text [$];
    int         fails      = 0;
    int         chars_seen = 0;
    int         items_sent = 0;

    t_dir_row dir_rows [20] = '{
        '{32'd0,           "0"},
        '{32'd1,           "1"},
        '{32'hFFFF_FFFF,   "-1"},
        '{32'h7FFF_FFFF,   "2147483647"},
        '{32'h8000_0000,   "-2147483648"},
        '{32'h8000_0001,   ""},
        '{32'd9,           ""},
        '{32'd10,          ""},
        '{-32'sd10,        ""},
        '{32'd99,          ""},
        '{32'd100,         ""},
        '{-32'sd7,         ""},
        '{32'd12345,       ""},
        '{32'd999999999,   ""},
        '{32'd1000000000,  ""},
        '{-32'sd999999999, ""},
        '{-32'sd1000000000, ""},
        '{32'h5555_5555,   ""},
        '{32'hAAAA_AAAA,   ""},
        '{32'd4000000,     ""}
    };

    signed_int_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
    end

    // sign, then digits most significant first, last flag on the final digit
    function automatic void predict_decimal_text(logic [W-1:0] v);
        logic             neg;
        logic [W-1:0]     mag;
        logic [7:0]       digs [$];
        neg = v[W-1];
        mag = neg ? (~v + 1'b1) : v;
        do begin
            digs.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (neg)
            pending_text.push_back('{CH_MINUS, 1'b0});
        foreach (digs[i])
            pending_text.push_back('{digs[i], i == digs.size() - 1});
    endfunction

    function automatic void expect_literal(string s);
        for (int i = 0; i < s.len(); i++)
            pending_text.push_back('{8'(s[i]), i == s.len() - 1});
    endfunction

    // mostly values of a chosen digit count, some at digit-count boundaries
    function automatic logic [W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     nd;
        int     kind;
        kind = $urandom_range(0, 3);
        if (kind == 0)
            return $urandom;
        nd = $urandom_range(1, 10);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = (nd == 10) ? 64'sd2147483647 : lo * 10 - 1;
        if (nd == 1)
            lo = 0;
        if (kind == 1)
            mag = $urandom_range(0, 1) ? lo : hi;
        else
            mag = lo + longint'($urandom) % (hi - lo + 1);
        if ($urandom_range(0, 1))
            mag = -mag;
        return W'(mag);
    endfunction

    task automatic send_value(logic [W-1:0] v, string text, bit allow_gap);
        int gap;
        start   <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        items_sent++;
        if (text.len() == 0)
            predict_decimal_text(v);
        else
            expect_literal(text);
        if (allow_gap && $urandom_range(0, 9) < 4) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_text.size() == 0) begin
                $display("%0t: unexpected char, expected none, got 0x%02h last=%b",
                         $time, o_char_code, o_last);
                fails++;
            end else begin
                want = pending_text.pop_front();
                chars_seen++;
                if (o_char_code !== want.code) begin
                    $display("%0t: char_code mismatch, expected 0x%02h, got 0x%02h",
                             $time, want.code, o_char_code);
                    fails++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch, expected %b, got %b",
                             $time, want.last, o_last);
                    fails++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_value(dir_rows[i].value, dir_rows[i].text, 1'b1);

        // no gaps in the last stretch so the queue stays full
        for (int n = 0; n < 100; n++)
            send_value(random_value(), "", n < 80);
        start <= 1'b0;

        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("converted %0d values, %0d characters checked, %0d mismatches",
                 items_sent, chars_seen, fails);
        if (fails == 0)
            $display("[signed_int_to_decimal_ascii] OK");
        else
            $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sia_pkg.sv
rtl/sia_front.sv
rtl/sia_queue.sv
rtl/sia_back.sv
rtl/signed_int_to_decimal_ascii.sv
bench/tb_signed_int_to_decimal_ascii.sv
